### sv/unea_pkg.sv
// ============================================================================
// unea_pkg
// Shared types, codes and reset constants of the urgent/normal event arbiter.
// ============================================================================
package unea_pkg;

    // Default queue depths.
    localparam int URGENT_DEPTH_DEF = 4;
    localparam int NORMAL_DEPTH_DEF = 12;

    // Stream widths: tdata is padded to whole bytes.
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 176;
    localparam int M_TUSER_W = 3;

    // Register port.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Register reset values.
    localparam logic [7:0]  URGENT_CODE_RST  = 8'd1;
    localparam logic [7:0]  NONE_CODE_RST    = 8'd0;
    localparam logic [7:0]  UNKNOWN_CODE_RST = 8'd255;
    localparam logic [15:0] MAX_AGE_RST      = 16'd1000;
    localparam logic [7:0]  URGENT_BURST_RST = 8'd4;

    // Streak counter saturates here.
    localparam logic [7:0] BURST_MAX = 8'hFF;

    // Kind of input beat.
    typedef enum logic [1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_SERVICE = 2'd1,
        ACT_FLUSH   = 2'd2,
        ACT_NOP     = 2'd3
    } action_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_IGNORED    = 3'd0,
        ST_QUEUED     = 3'd1,
        ST_DROPPED    = 3'd2,
        ST_IDLE       = 3'd3,
        ST_EXPIRED    = 3'd4,
        ST_DISPATCHED = 3'd5,
        ST_FLUSHED    = 3'd6
    } status_t;

    // Outcome decided when a beat is taken; a pop is resolved in the execute stage.
    typedef enum logic [2:0] {
        KIND_IGNORED = 3'd0,
        KIND_QUEUED  = 3'd1,
        KIND_DROPPED = 3'd2,
        KIND_IDLE    = 3'd3,
        KIND_POP     = 3'd4,
        KIND_FLUSHED = 3'd5
    } res_kind_t;

    // Register indexes (byte address divided by four).
    typedef enum logic [2:0] {
        REG_URGENT_CODE  = 3'd0,
        REG_NONE_CODE    = 3'd1,
        REG_UNKNOWN_CODE = 3'd2,
        REG_MAX_AGE      = 3'd3,
        REG_URGENT_BURST = 3'd4
    } reg_idx_t;

    // One queued event: 41 bits.
    typedef struct packed {
        logic [31:0] stamp;
        logic [7:0]  code;
        logic        remote;
    } entry_t;

endpackage

### sv/urgent_normal_event_arbiter.sv
// A taken beat is held in the execute stage, then in the output register (m_tvalid).
// Throughput: one item per cycle unless the output stalls; each item makes at most one
// access to one queue memory when taken; the following stage resolves a pop from read data.
// Reset (aresetn low, synchronous) empties both queues, clears the streak and the
// counters and restores the register defaults; the queue memories are not cleared.
// ============================================================================
// urgent_normal_event_arbiter
// Two timestamped event queues in synchronous memories, served urgent first
// under a burst limit, with expiry on age and running event counters.
// ============================================================================
module urgent_normal_event_arbiter #(
    parameter int URGENT_DEPTH = unea_pkg::URGENT_DEPTH_DEF,
    parameter int NORMAL_DEPTH = unea_pkg::NORMAL_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // now_ms[31:0], source_remote[32], message[40:33], zero pad [47:41]
    input  logic [unea_pkg::S_TDATA_W-1:0]    s_tdata,
    // action[1:0]
    input  logic [unea_pkg::S_TUSER_W-1:0]    s_tuser,
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_message[7:0], out_remote[8], out_from_urgent[9], count_queued[41:10],
    // count_dropped[73:42], count_expired[105:74], count_dispatched[137:106],
    // count_flushes[169:138], zero pad [175:170]
    output logic [unea_pkg::M_TDATA_W-1:0]    m_tdata,
    // status[2:0]
    output logic [unea_pkg::M_TUSER_W-1:0]    m_tuser,
    // Register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [unea_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [unea_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [unea_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int U_IDX_W  = (URGENT_DEPTH > 1) ? $clog2(URGENT_DEPTH) : 1;
    localparam int U_FILL_W = $clog2(URGENT_DEPTH + 1);
    localparam int U_SUM_W  = U_FILL_W + 1;
    localparam int N_IDX_W  = (NORMAL_DEPTH > 1) ? $clog2(NORMAL_DEPTH) : 1;
    localparam int N_FILL_W = $clog2(NORMAL_DEPTH + 1);
    localparam int N_SUM_W  = N_FILL_W + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]  urgent_code_reg;
    logic [7:0]  none_code_reg;
    logic [7:0]  unknown_code_reg;
    logic [15:0] max_age_reg;
    logic [7:0]  urgent_burst_reg;
    logic        cfg_wr;
    unea_pkg::reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = unea_pkg::reg_idx_t'(paddr[4:2]);

    // Register writes; an address beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            urgent_code_reg  <= unea_pkg::URGENT_CODE_RST;
            none_code_reg    <= unea_pkg::NONE_CODE_RST;
            unknown_code_reg <= unea_pkg::UNKNOWN_CODE_RST;
            max_age_reg      <= unea_pkg::MAX_AGE_RST;
            urgent_burst_reg <= unea_pkg::URGENT_BURST_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                unea_pkg::REG_URGENT_CODE:  urgent_code_reg  <= pwdata[7:0];
                unea_pkg::REG_NONE_CODE:    none_code_reg    <= pwdata[7:0];
                unea_pkg::REG_UNKNOWN_CODE: unknown_code_reg <= pwdata[7:0];
                unea_pkg::REG_MAX_AGE:      max_age_reg      <= pwdata[15:0];
                unea_pkg::REG_URGENT_BURST: urgent_burst_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (cfg_idx)
            unea_pkg::REG_URGENT_CODE:  prdata = 32'(urgent_code_reg);
            unea_pkg::REG_NONE_CODE:    prdata = 32'(none_code_reg);
            unea_pkg::REG_UNKNOWN_CODE: prdata = 32'(unknown_code_reg);
            unea_pkg::REG_MAX_AGE:      prdata = 32'(max_age_reg);
            unea_pkg::REG_URGENT_BURST: prdata = 32'(urgent_burst_reg);
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Queue pointers, streak and pipeline registers
    // ------------------------------------------------------------------
    logic [U_IDX_W-1:0]  urgent_head_reg, urgent_head_next;
    logic [U_FILL_W-1:0] urgent_fill_reg, urgent_fill_next;
    logic [N_IDX_W-1:0]  normal_head_reg, normal_head_next;
    logic [N_FILL_W-1:0] normal_fill_reg, normal_fill_next;
    logic [7:0]          burst_reg, burst_next;

    logic                    ex_valid_reg, ex_valid_next;
    unea_pkg::res_kind_t     ex_kind_reg, acc_kind;
    logic                    ex_urgent_reg, acc_urgent;
    logic [31:0]             ex_now_reg;

    logic                    m_valid_reg, m_valid_next;
    unea_pkg::status_t       m_status_reg, res_status;
    logic [7:0]              m_msg_reg, res_msg;
    logic                    m_remote_reg, res_remote;
    logic                    m_urgent_reg, res_urgent;

    logic [31:0] cnt_queued_reg, cnt_dropped_reg, cnt_expired_reg;
    logic [31:0] cnt_dispatched_reg, cnt_flushes_reg;

    // Input beat fields.
    unea_pkg::action_t in_action;
    logic [31:0]       in_now;
    logic              in_remote;
    logic [7:0]        in_msg;
    unea_pkg::entry_t  wr_entry;
    logic              s_accept;
    logic              ex_move;

    assign in_action = unea_pkg::action_t'(s_tuser[1:0]);
    assign in_now    = s_tdata[31:0];
    assign in_remote = s_tdata[32];
    assign in_msg    = s_tdata[40:33];
    assign wr_entry  = '{stamp: in_now, code: in_msg, remote: in_remote};

    // The execute stage drains into the output register; a new beat is taken
    // whenever the execute stage is empty or empties in this cycle.
    assign ex_move  = ex_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !ex_valid_reg || ex_move;
    assign s_accept = s_tvalid && s_tready;

    // Write positions (head plus fill, wrapped) and advanced heads.
    logic [U_SUM_W-1:0] u_tail_sum, u_tail_wrap;
    logic [N_SUM_W-1:0] n_tail_sum, n_tail_wrap;
    logic [U_IDX_W-1:0] u_tail_idx, u_head_inc;
    logic [N_IDX_W-1:0] n_tail_idx, n_head_inc;
    logic               u_full, n_full, u_empty, n_empty;

    always_comb begin
        u_tail_sum  = U_SUM_W'(urgent_head_reg) + U_SUM_W'(urgent_fill_reg);
        u_tail_wrap = (u_tail_sum >= U_SUM_W'(URGENT_DEPTH)) ?
                      u_tail_sum - U_SUM_W'(URGENT_DEPTH) : u_tail_sum;
        u_tail_idx  = u_tail_wrap[U_IDX_W-1:0];
        u_head_inc  = (urgent_head_reg == U_IDX_W'(URGENT_DEPTH - 1)) ?
                      '0 : urgent_head_reg + U_IDX_W'(1);
        n_tail_sum  = N_SUM_W'(normal_head_reg) + N_SUM_W'(normal_fill_reg);
        n_tail_wrap = (n_tail_sum >= N_SUM_W'(NORMAL_DEPTH)) ?
                      n_tail_sum - N_SUM_W'(NORMAL_DEPTH) : n_tail_sum;
        n_tail_idx  = n_tail_wrap[N_IDX_W-1:0];
        n_head_inc  = (normal_head_reg == N_IDX_W'(NORMAL_DEPTH - 1)) ?
                      '0 : normal_head_reg + N_IDX_W'(1);
        u_full      = (urgent_fill_reg >= U_FILL_W'(URGENT_DEPTH));
        n_full      = (normal_fill_reg >= N_FILL_W'(NORMAL_DEPTH));
        u_empty     = (urgent_fill_reg == '0);
        n_empty     = (normal_fill_reg == '0);
    end

    // Decision on a taken beat: queue updates and at most one memory access.
    logic u_wr_en, n_wr_en, u_rd_en, n_rd_en;

    always_comb begin
        urgent_head_next = urgent_head_reg;
        urgent_fill_next = urgent_fill_reg;
        normal_head_next = normal_head_reg;
        normal_fill_next = normal_fill_reg;
        burst_next       = burst_reg;
        u_wr_en          = 1'b0;
        n_wr_en          = 1'b0;
        u_rd_en          = 1'b0;
        n_rd_en          = 1'b0;
        acc_kind         = unea_pkg::KIND_IGNORED;
        acc_urgent       = 1'b0;
        if (s_accept) begin
            unique case (in_action)
                unea_pkg::ACT_ENQUEUE: begin
                    // The none and unknown codes are checked before the urgent code.
                    if (in_msg != none_code_reg && in_msg != unknown_code_reg) begin
                        if (in_msg == urgent_code_reg) begin
                            if (u_full) begin
                                acc_kind = unea_pkg::KIND_DROPPED;
                            end else begin
                                u_wr_en          = 1'b1;
                                urgent_fill_next = urgent_fill_reg + U_FILL_W'(1);
                                acc_kind         = unea_pkg::KIND_QUEUED;
                            end
                        end else begin
                            if (n_full) begin
                                acc_kind = unea_pkg::KIND_DROPPED;
                            end else begin
                                n_wr_en          = 1'b1;
                                normal_fill_next = normal_fill_reg + N_FILL_W'(1);
                                acc_kind         = unea_pkg::KIND_QUEUED;
                            end
                        end
                    end
                end
                unea_pkg::ACT_SERVICE: begin
                    if (!u_empty && (n_empty || burst_reg < urgent_burst_reg)) begin
                        u_rd_en          = 1'b1;
                        urgent_head_next = u_head_inc;
                        urgent_fill_next = urgent_fill_reg - U_FILL_W'(1);
                        if (burst_reg != unea_pkg::BURST_MAX) begin
                            burst_next = burst_reg + 8'd1;
                        end
                        acc_kind   = unea_pkg::KIND_POP;
                        acc_urgent = 1'b1;
                    end else if (!n_empty) begin
                        n_rd_en          = 1'b1;
                        normal_head_next = n_head_inc;
                        normal_fill_next = normal_fill_reg - N_FILL_W'(1);
                        burst_next       = '0;
                        acc_kind         = unea_pkg::KIND_POP;
                    end else begin
                        acc_kind = unea_pkg::KIND_IDLE;
                    end
                end
                unea_pkg::ACT_FLUSH: begin
                    urgent_head_next = '0;
                    urgent_fill_next = '0;
                    normal_head_next = '0;
                    normal_fill_next = '0;
                    burst_next       = '0;
                    acc_kind         = unea_pkg::KIND_FLUSHED;
                end
                unea_pkg::ACT_NOP: begin
                    acc_kind = unea_pkg::KIND_IGNORED;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Queue memories. Each taken beat writes or reads at most one entry, and
    // a write is committed before any later beat's read, so no forwarding.
    // ------------------------------------------------------------------
    unea_pkg::entry_t urgent_mem [URGENT_DEPTH];
    unea_pkg::entry_t normal_mem [NORMAL_DEPTH];
    unea_pkg::entry_t u_rd_reg, n_rd_reg;

    always_ff @(posedge aclk) begin
        if (u_wr_en) begin
            urgent_mem[u_tail_idx] <= wr_entry;
        end
        if (u_rd_en) begin
            u_rd_reg <= urgent_mem[urgent_head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (n_wr_en) begin
            normal_mem[n_tail_idx] <= wr_entry;
        end
        if (n_rd_en) begin
            n_rd_reg <= normal_mem[normal_head_reg];
        end
    end

    // ------------------------------------------------------------------
    // Execute stage: age check on the popped entry and the result fields.
    // ------------------------------------------------------------------
    unea_pkg::entry_t rd_entry;
    logic [31:0]      age;
    logic             expired;

    always_comb begin
        rd_entry   = ex_urgent_reg ? u_rd_reg : n_rd_reg;
        age        = ex_now_reg - rd_entry.stamp;
        expired    = (age >= 32'(max_age_reg));
        res_msg    = '0;
        res_remote = 1'b0;
        res_urgent = 1'b0;
        case (ex_kind_reg)
            unea_pkg::KIND_IGNORED: res_status = unea_pkg::ST_IGNORED;
            unea_pkg::KIND_QUEUED:  res_status = unea_pkg::ST_QUEUED;
            unea_pkg::KIND_DROPPED: res_status = unea_pkg::ST_DROPPED;
            unea_pkg::KIND_IDLE:    res_status = unea_pkg::ST_IDLE;
            unea_pkg::KIND_POP: begin
                res_status = expired ? unea_pkg::ST_EXPIRED : unea_pkg::ST_DISPATCHED;
                res_msg    = rd_entry.code;
                res_remote = rd_entry.remote;
                res_urgent = ex_urgent_reg;
            end
            unea_pkg::KIND_FLUSHED: res_status = unea_pkg::ST_FLUSHED;
            default:                res_status = unea_pkg::ST_IGNORED;
        endcase
    end

    // Valid flags of the two stages.
    always_comb begin
        ex_valid_next = s_accept ? 1'b1 : (ex_move ? 1'b0 : ex_valid_reg);
        m_valid_next  = ex_move ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            urgent_head_reg <= '0;
            urgent_fill_reg <= '0;
            normal_head_reg <= '0;
            normal_fill_reg <= '0;
            burst_reg       <= '0;
            ex_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            urgent_head_reg <= urgent_head_next;
            urgent_fill_reg <= urgent_fill_next;
            normal_head_reg <= normal_head_next;
            normal_fill_reg <= normal_fill_next;
            burst_reg       <= burst_next;
            ex_valid_reg    <= ex_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Counters move only when a result enters the output register, so they
    // always match the beat on show.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_queued_reg     <= '0;
            cnt_dropped_reg    <= '0;
            cnt_expired_reg    <= '0;
            cnt_dispatched_reg <= '0;
            cnt_flushes_reg    <= '0;
        end else if (ex_move) begin
            case (res_status)
                unea_pkg::ST_QUEUED:     cnt_queued_reg     <= cnt_queued_reg + 32'd1;
                unea_pkg::ST_DROPPED:    cnt_dropped_reg    <= cnt_dropped_reg + 32'd1;
                unea_pkg::ST_EXPIRED:    cnt_expired_reg    <= cnt_expired_reg + 32'd1;
                unea_pkg::ST_DISPATCHED: cnt_dispatched_reg <= cnt_dispatched_reg + 32'd1;
                unea_pkg::ST_FLUSHED:    cnt_flushes_reg    <= cnt_flushes_reg + 32'd1;
                default: ;
            endcase
        end
    end

    // Payload of the execute stage and the output register.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ex_kind_reg   <= acc_kind;
            ex_urgent_reg <= acc_urgent;
            ex_now_reg    <= in_now;
        end
        if (ex_move) begin
            m_status_reg <= res_status;
            m_msg_reg    <= res_msg;
            m_remote_reg <= res_remote;
            m_urgent_reg <= res_urgent;
        end
    end

    // Result beat.
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {6'b0, cnt_flushes_reg, cnt_dispatched_reg, cnt_expired_reg,
                       cnt_dropped_reg, cnt_queued_reg, m_urgent_reg, m_remote_reg,
                       m_msg_reg};

endmodule

### sv/unea_checker.sv
// ============================================================================
// unea_checker
// Port-level checks on the event arbiter's streams, bound to the top level.
// ============================================================================
module unea_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tready,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [unea_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [unea_pkg::M_TUSER_W-1:0] m_tuser
);

    logic        m_beat;
    logic        is_pop;
    logic [31:0] flushes_seen_reg;

    assign m_beat = m_tvalid && m_tready;
    assign is_pop = (m_tuser == unea_pkg::ST_EXPIRED) || (m_tuser == unea_pkg::ST_DISPATCHED);

    // Flush count carried by the last delivered beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flushes_seen_reg <= '0;
        end else if (m_beat) begin
            flushes_seen_reg <= m_tdata[169:138];
        end
    end

    // A held result keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result beat changed while stalled");

    // Event fields are zero unless an event was popped.
    a_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !is_pop) |-> (m_tdata[9:0] == 10'd0))
        else $error("event fields set on a result without a pop");

    // The flush count steps by one on a flush result and holds otherwise.
    a_flush_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_beat |-> (m_tdata[169:138] ==
                    flushes_seen_reg + ((m_tuser == unea_pkg::ST_FLUSHED) ? 32'd1 : 32'd0)))
        else $error("flush count out of step with flush results");

    // With no result waiting, the input side is never blocked.
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output register");

endmodule

bind urgent_normal_event_arbiter unea_checker u_unea_checker (.*);

### verif/urgent_normal_event_arbiter_checker.sv
// ============================================================================
// urgent_normal_event_arbiter_checker
// Watches the register port and both stream channels of the arbiter. Every
// input beat taken is run through a cycle-free model of the two event queues,
// and the outcome is held until the matching result beat arrives, where it
// is compared field by field.
// ============================================================================
module urgent_normal_event_arbiter_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // now_ms[31:0], source_remote[32], message[40:33], zero pad [47:41]
    input  logic [unea_pkg::S_TDATA_W-1:0]   s_tdata,
    // action[1:0]
    input  logic [unea_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // out_message[7:0], out_remote[8], out_from_urgent[9], count_queued[41:10],
    // count_dropped[73:42], count_expired[105:74], count_dispatched[137:106],
    // count_flushes[169:138], zero pad [175:170]
    input  logic [unea_pkg::M_TDATA_W-1:0]   m_tdata,
    // status[2:0]
    input  logic [unea_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic                             pready,
    input  logic [unea_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [unea_pkg::APB_DATA_W-1:0]  pwdata,
    output int                               fail_count,
    output int                               pending
);

    localparam int URGENT_SLOTS = unea_pkg::URGENT_DEPTH_DEF;
    localparam int NORMAL_SLOTS = unea_pkg::NORMAL_DEPTH_DEF;

    // One predicted result beat.
    typedef struct packed {
        unea_pkg::status_t status;
        logic [7:0]        code;
        logic              remote;
        logic              from_urgent;
        logic [31:0]       queued;
        logic [31:0]       dropped;
        logic [31:0]       expired;
        logic [31:0]       dispatched;
        logic [31:0]       flushes;
    } outcome_t;

    // Register copies.
    logic [7:0]  urgent_reg;
    logic [7:0]  none_reg;
    logic [7:0]  unknown_reg;
    logic [15:0] age_limit;
    logic [7:0]  burst_limit;

    // Queue contents, streak and running totals.
    unea_pkg::entry_t urgent_q[$];
    unea_pkg::entry_t normal_q[$];
    logic [7:0]  streak;
    logic [31:0] queued_total;
    logic [31:0] dropped_total;
    logic [31:0] expired_total;
    logic [31:0] dispatched_total;
    logic [31:0] flush_total;

    outcome_t    outcomes[$];
    int          mismatches = 0;

    // Applies one item to the queues and returns the result it must produce.
    function automatic outcome_t arbitrate(unea_pkg::action_t act, logic [31:0] now,
                                           logic remote, logic [7:0] code);
        outcome_t         o;
        unea_pkg::entry_t ev;
        logic             stored;
        logic             popped;
        o = '0;
        stored = 1'b0;
        popped = 1'b0;
        case (act)
            unea_pkg::ACT_ENQUEUE: begin
                // The none and unknown codes win over the urgent code.
                if (code != none_reg && code != unknown_reg) begin
                    ev.stamp = now;
                    ev.code = code;
                    ev.remote = remote;
                    if (code == urgent_reg) begin
                        if (urgent_q.size() < URGENT_SLOTS) begin
                            urgent_q.push_back(ev);
                            stored = 1'b1;
                        end
                    end else if (normal_q.size() < NORMAL_SLOTS) begin
                        normal_q.push_back(ev);
                        stored = 1'b1;
                    end
                    if (stored) begin
                        queued_total = queued_total + 32'd1;
                        o.status = unea_pkg::ST_QUEUED;
                    end else begin
                        dropped_total = dropped_total + 32'd1;
                        o.status = unea_pkg::ST_DROPPED;
                    end
                end else begin
                    o.status = unea_pkg::ST_IGNORED;
                end
            end
            unea_pkg::ACT_SERVICE: begin
                // Urgent first, unless the streak has used up the burst allowance
                // while normal events are waiting.
                if (urgent_q.size() != 0 && (normal_q.size() == 0 || streak < burst_limit)) begin
                    ev = urgent_q.pop_front();
                    if (streak != unea_pkg::BURST_MAX)
                        streak = streak + 8'd1;
                    o.from_urgent = 1'b1;
                    popped = 1'b1;
                end else if (normal_q.size() != 0) begin
                    ev = normal_q.pop_front();
                    streak = '0;
                    popped = 1'b1;
                end
                if (popped) begin
                    o.code = ev.code;
                    o.remote = ev.remote;
                    if ((now - ev.stamp) >= {16'd0, age_limit}) begin
                        expired_total = expired_total + 32'd1;
                        o.status = unea_pkg::ST_EXPIRED;
                    end else begin
                        dispatched_total = dispatched_total + 32'd1;
                        o.status = unea_pkg::ST_DISPATCHED;
                    end
                end else begin
                    o.status = unea_pkg::ST_IDLE;
                end
            end
            unea_pkg::ACT_FLUSH: begin
                urgent_q.delete();
                normal_q.delete();
                streak = '0;
                flush_total = flush_total + 32'd1;
                o.status = unea_pkg::ST_FLUSHED;
            end
            default: o.status = unea_pkg::ST_IGNORED;
        endcase
        o.queued = queued_total;
        o.dropped = dropped_total;
        o.expired = expired_total;
        o.dispatched = dispatched_total;
        o.flushes = flush_total;
        return o;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Register writes, results against the oldest outcome, then new input beats.
    always @(posedge aclk) begin : watch
        outcome_t want;
        if (!aresetn) begin
            urgent_reg = unea_pkg::URGENT_CODE_RST;
            none_reg = unea_pkg::NONE_CODE_RST;
            unknown_reg = unea_pkg::UNKNOWN_CODE_RST;
            age_limit = unea_pkg::MAX_AGE_RST;
            burst_limit = unea_pkg::URGENT_BURST_RST;
            urgent_q.delete();
            normal_q.delete();
            streak = '0;
            queued_total = '0;
            dropped_total = '0;
            expired_total = '0;
            dispatched_total = '0;
            flush_total = '0;
            outcomes.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    unea_pkg::REG_URGENT_CODE:  urgent_reg = pwdata[7:0];
                    unea_pkg::REG_NONE_CODE:    none_reg = pwdata[7:0];
                    unea_pkg::REG_UNKNOWN_CODE: unknown_reg = pwdata[7:0];
                    unea_pkg::REG_MAX_AGE:      age_limit = pwdata[15:0];
                    unea_pkg::REG_URGENT_BURST: burst_limit = pwdata[7:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (outcomes.size() == 0) begin
                    $error("result beat arrived with no outstanding item");
                    mismatches++;
                end else begin
                    want = outcomes.pop_front();
                    check_field("status", want.status, m_tuser);
                    check_field("out_message", want.code, m_tdata[7:0]);
                    check_field("out_remote", want.remote, m_tdata[8]);
                    check_field("out_from_urgent", want.from_urgent, m_tdata[9]);
                    check_field("count_queued", want.queued, m_tdata[41:10]);
                    check_field("count_dropped", want.dropped, m_tdata[73:42]);
                    check_field("count_expired", want.expired, m_tdata[105:74]);
                    check_field("count_dispatched", want.dispatched, m_tdata[137:106]);
                    check_field("count_flushes", want.flushes, m_tdata[169:138]);
                end
            end
            if (s_tvalid && s_tready)
                outcomes.push_back(arbitrate(unea_pkg::action_t'(s_tuser), s_tdata[31:0],
                                             s_tdata[32], s_tdata[40:33]));
        end
        pending <= outcomes.size();
        fail_count <= mismatches;
    end

endmodule

### verif/urgent_normal_event_arbiter_tb.sv
// ============================================================================
// urgent_normal_event_arbiter_tb
// Drives the arbiter with a directed opening and then random event traffic
// under a series of register settings, with random gaps on both channels.
// The checker beside the block predicts and compares every result beat.
// ============================================================================
module urgent_normal_event_arbiter_tb;

    localparam int         HALF_PERIOD   = 4;
    localparam int         RESET_CYCLES  = 12;
    localparam int         IDLE_PCT      = 13;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         STALL_LIMIT   = 1000;
    localparam int         PHASE_BEATS   = 120;
    // Register slot past the last one; writes to it must have no effect.
    localparam logic [2:0] REG_BEYOND    = 3'd5;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [unea_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic [unea_pkg::S_TUSER_W-1:0]  s_tuser = unea_pkg::ACT_NOP;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [unea_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [unea_pkg::M_TUSER_W-1:0]  m_tuser;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [unea_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [unea_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [unea_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    int                    fail_count;
    int                    pending;
    int                    quiet_cycles = 0;
    logic                  steady = 1'b0;
    logic [31:0]           wall_ms = 32'd0;

    // Codes currently programmed, used to steer the random messages.
    logic [7:0]            cfg_urgent = unea_pkg::URGENT_CODE_RST;
    logic [7:0]            cfg_none = unea_pkg::NONE_CODE_RST;
    logic [7:0]            cfg_unknown = unea_pkg::UNKNOWN_CODE_RST;

    urgent_normal_event_arbiter dut (.*);

    urgent_normal_event_arbiter_checker chk (.*);

    always #HALF_PERIOD aclk = ~aclk;

    // The result side stalls at random except during a steady stretch.
    always @(posedge aclk)
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    // Ends the run if nothing moves on any port for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("urgent_normal_event_arbiter: mismatch");
                $finish;
            end
        end
    end

    // Presents one beat, possibly after a gap with s_tvalid low, and waits until it is taken.
    task automatic send_beat(unea_pkg::action_t act, logic [31:0] stamp, logic remote,
                             logic [7:0] code);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tuser <= act;
        s_tdata <= {7'd0, code, remote, stamp};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops sending and waits for every outstanding result beat.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    // Programs all five registers once the block is idle; upper bits carry junk.
    task automatic apply_settings(logic [7:0] urg, logic [7:0] nul, logic [7:0] unk,
                                  logic [15:0] age, logic [7:0] burst);
        drain_results();
        write_reg(unea_pkg::REG_URGENT_CODE, {24'($urandom()), urg});
        write_reg(unea_pkg::REG_NONE_CODE, {24'($urandom()), nul});
        write_reg(unea_pkg::REG_UNKNOWN_CODE, {24'($urandom()), unk});
        write_reg(unea_pkg::REG_MAX_AGE, {16'($urandom()), age});
        write_reg(unea_pkg::REG_URGENT_BURST, {24'($urandom()), burst});
        cfg_urgent = urg;
        cfg_none = nul;
        cfg_unknown = unk;
    endtask

    // Mostly the urgent code, some ignored codes, the rest anything.
    function automatic logic [7:0] pick_message();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            return cfg_urgent;
        if (roll == 4)
            return cfg_none;
        if (roll == 5)
            return cfg_unknown;
        return 8'($urandom_range(0, 255));
    endfunction

    // A code that lands in the normal queue.
    function automatic logic [7:0] plain_message();
        logic [7:0] m;
        do m = 8'($urandom_range(0, 255));
        while (m == cfg_urgent || m == cfg_none || m == cfg_unknown);
        return m;
    endfunction

    task automatic random_beat(int enqueue_pct);
        int                roll;
        unea_pkg::action_t act;
        roll = $urandom_range(0, 99);
        if (roll < enqueue_pct)
            act = unea_pkg::ACT_ENQUEUE;
        else if (roll < 97)
            act = unea_pkg::ACT_SERVICE;
        else if (roll < 98)
            act = unea_pkg::ACT_FLUSH;
        else
            act = unea_pkg::ACT_NOP;
        // Time creeps forward, with the odd jump anywhere in the range.
        if ($urandom_range(0, 49) == 0)
            wall_ms = $urandom();
        else
            wall_ms = wall_ms + 32'($urandom_range(0, 40));
        send_beat(act, wall_ms, 1'($urandom_range(0, 1)), pick_message());
    endtask

    // Alternating stretches that fill the queues and that empty them.
    task automatic run_phase(int beats);
        for (int i = 0; i < beats; i++) begin
            random_beat(((i / 30) % 2 == 0) ? 75 : 30);
            if ($urandom_range(0, 99) == 0)
                drain_results();
        end
    endtask

    // Drives the urgent streak past its saturation point, then checks that a
    // waiting normal event still beats the next urgent one.
    task automatic streak_run();
        send_beat(unea_pkg::ACT_FLUSH, wall_ms, 1'b0, cfg_none);
        repeat (260) begin
            wall_ms = wall_ms + 32'd1;
            send_beat(unea_pkg::ACT_ENQUEUE, wall_ms, 1'b1, cfg_urgent);
            send_beat(unea_pkg::ACT_SERVICE, wall_ms, 1'b0, 8'h00);
        end
        send_beat(unea_pkg::ACT_ENQUEUE, wall_ms, 1'b0, plain_message());
        send_beat(unea_pkg::ACT_ENQUEUE, wall_ms, 1'b1, cfg_urgent);
        send_beat(unea_pkg::ACT_SERVICE, wall_ms, 1'b0, 8'h00);
        send_beat(unea_pkg::ACT_SERVICE, wall_ms, 1'b0, 8'h00);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening under the reset settings: empty service, ignored
        // codes, the unused action, both queues overflowing, the burst limit
        // giving way to a normal event, expiry across a wrap, and a flush.
        send_beat(unea_pkg::ACT_SERVICE, 32'd0, 1'b0, 8'h00);
        send_beat(unea_pkg::ACT_ENQUEUE, 32'd5, 1'b1, unea_pkg::NONE_CODE_RST);
        send_beat(unea_pkg::ACT_ENQUEUE, 32'd6, 1'b0, unea_pkg::UNKNOWN_CODE_RST);
        send_beat(unea_pkg::ACT_NOP, 32'hFFFF_FFFF, 1'b1, 8'hFF);
        for (int i = 0; i < 5; i++)
            send_beat(unea_pkg::ACT_ENQUEUE, 32'hFFFF_FFF0, i[0], unea_pkg::URGENT_CODE_RST);
        for (int i = 0; i < 13; i++)
            send_beat(unea_pkg::ACT_ENQUEUE, 32'hFFFF_FFF8, ~i[0], 8'(2 + 19 * i));
        repeat (4) send_beat(unea_pkg::ACT_SERVICE, 32'h0000_0010, 1'b0, 8'h00);
        send_beat(unea_pkg::ACT_ENQUEUE, 32'h0001_0000, 1'b1, unea_pkg::URGENT_CODE_RST);
        send_beat(unea_pkg::ACT_SERVICE, 32'h0001_0000, 1'b0, 8'h00);
        send_beat(unea_pkg::ACT_SERVICE, 32'h0001_0000, 1'b0, 8'h00);
        send_beat(unea_pkg::ACT_FLUSH, 32'h0001_0001, 1'b1, 8'h00);
        wall_ms = 32'h0001_0001;

        // Random traffic under a sequence of settings, extremes included.
        apply_settings(8'h01, 8'h00, 8'hFF, 16'd1000, 8'd4);
        run_phase(PHASE_BEATS);
        apply_settings(8'h80, 8'h7F, 8'h7F, 16'd0, 8'd0);
        run_phase(PHASE_BEATS);
        apply_settings(8'h55, 8'h55, 8'hAA, 16'd1, 8'd1);
        write_reg(REG_BEYOND, 32'hFFFF_FFFF);
        run_phase(PHASE_BEATS);
        apply_settings(8'h00, 8'hFF, 8'hFE, 16'hFFFF, 8'hFF);
        wall_ms = 32'hFFFF_FF00;
        streak_run();
        run_phase(PHASE_BEATS);

        // A stretch with no gaps on either side.
        drain_results();
        steady <= 1'b1;
        apply_settings(8'($urandom()), 8'($urandom()), 8'($urandom()),
                       16'($urandom_range(0, 2000)), 8'($urandom_range(0, 8)));
        run_phase(PHASE_BEATS);
        drain_results();
        steady <= 1'b0;

        apply_settings(8'hFE, 8'h01, 8'h00, 16'd300, 8'd2);
        run_phase(PHASE_BEATS);
        drain_results();

        if (fail_count == 0)
            $display("urgent_normal_event_arbiter: match");
        else
            $display("urgent_normal_event_arbiter: mismatch");
        $finish;
    end

endmodule

### sim.f
sv/unea_pkg.sv
sv/urgent_normal_event_arbiter.sv
sv/unea_checker.sv
verif/urgent_normal_event_arbiter_checker.sv
verif/urgent_normal_event_arbiter_tb.sv
